// ===== hdl/spcf_pkg.sv =====
package spcf_pkg;

    // Shadow store geometry.
    localparam int SHADOW_ENTRIES = 4096;
    localparam int SHADOW_AW      = $clog2(SHADOW_ENTRIES);

    // Field widths.
    localparam int ADDR_W  = 32;
    localparam int GRAN_W  = 29;
    localparam int CNT_W   = 16;
    localparam int REM_W   = 17;
    localparam int NGRAN_W = 14;
    localparam int VAL_W   = 8;

    // Number of classified requests held between the front and the back.
    localparam int QUEUE_DEPTH = 2;

    // Entry offsets at or above this limit lie outside the shadow store.
    localparam logic [GRAN_W-1:0] ENTRIES_LIM = GRAN_W'(SHADOW_ENTRIES);

    // Request kinds.
    localparam logic [1:0] KIND_FILL = 2'd0;
    localparam logic [1:0] KIND_ANY  = 2'd1;
    localparam logic [1:0] KIND_ALL  = 2'd2;
    localparam logic [1:0] KIND_NONE = 2'd3;

    // One classified request: where the walk starts and how far it goes.
    typedef struct packed {
        logic [1:0]         op;
        logic [GRAN_W-1:0]  off;
        logic [GRAN_W-1:0]  gran;
        logic [NGRAN_W-1:0] ngran;
        logic [REM_W-1:0]   rem;
        logic [VAL_W-1:0]   value;
    } job_t;

endpackage

// ===== hdl/shadow_poison_check_fill.sv =====
// Channel   Direction  Handshake              Contents
// cfg       in         cfg_we                 cfg_wdata: shadow region base granule
// request   in         in_valid / in_ready    kind, base_addr, byte_count, fill_value
// result    out        out_valid / out_ready  verdict, first_invalid_addr, skipped_out_of_range
//
// After reset the shadow store is zeroed one entry per cycle, all 4096 entries, with in_ready low.
// A request walks one shadow entry per cycle over the shadow RAM: a fill or a check posts its
// result once it has walked all its granules, and a check that decides at an earlier granule
// stops its walk at that granule and posts its result.
// Three requests can wait, one in the front and two in the queue, while the back walks or
// its result stalls. The back starts a new walk only once the previous result transaction
// has completed.
module shadow_poison_check_fill (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spcf_pkg::GRAN_W-1:0]   cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [spcf_pkg::ADDR_W-1:0]   base_addr,
    input  logic [spcf_pkg::CNT_W-1:0]    byte_count,
    input  logic [spcf_pkg::VAL_W-1:0]    fill_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          verdict,
    output logic [spcf_pkg::ADDR_W-1:0]   first_invalid_addr,
    output logic                          skipped_out_of_range
);

    logic [spcf_pkg::GRAN_W-1:0] region_base_reg;
    logic                        clear_done;
    logic                        push_valid;
    logic                        push_ready;
    spcf_pkg::job_t              push_job;
    logic                        pop_valid;
    logic                        pop_ready;
    spcf_pkg::job_t              pop_job;

    // Region base register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
        end
        else if (cfg_we)
        begin
            region_base_reg <= cfg_wdata;
        end
    end

    spcf_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .enable     (clear_done),
        .region_base(region_base_reg),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .base_addr  (base_addr),
        .byte_count (byte_count),
        .fill_value (fill_value),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    spcf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_job  (push_job),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job)
    );

    spcf_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .clear_done          (clear_done),
        .pop_valid           (pop_valid),
        .pop_ready           (pop_ready),
        .pop_job             (pop_job),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .verdict             (verdict),
        .first_invalid_addr  (first_invalid_addr),
        .skipped_out_of_range(skipped_out_of_range)
    );

endmodule

// ===== hdl/spcf_ram.sv =====
module spcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hdl/spcf_front.sv =====
module spcf_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          enable,
    input  logic [spcf_pkg::GRAN_W-1:0]   region_base,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    kind,
    input  logic [spcf_pkg::ADDR_W-1:0]   base_addr,
    input  logic [spcf_pkg::CNT_W-1:0]    byte_count,
    input  logic [spcf_pkg::VAL_W-1:0]    fill_value,
    output logic                          push_valid,
    input  logic                          push_ready,
    output spcf_pkg::job_t                push_job
);

    logic                           fv_reg;
    logic                           fv_next;
    spcf_pkg::job_t                 job_reg;
    spcf_pkg::job_t                 job_next;

    logic [2:0]                     lead;
    logic                           lead_nz;
    logic [3:0]                     rest;
    logic                           fill_go;
    logic [spcf_pkg::CNT_W-1:0]     fill_cnt;
    logic [spcf_pkg::GRAN_W-1:0]    fill_gran;
    logic [spcf_pkg::REM_W-1:0]     fill_sum;
    logic [spcf_pkg::REM_W-1:0]     chk_rem;
    logic [spcf_pkg::REM_W-1:0]     chk_sum;
    logic [spcf_pkg::GRAN_W-1:0]    gran;
    logic                           accept;

    assign in_ready   = enable && (!fv_reg || push_ready);
    assign accept     = in_valid && in_ready;
    assign push_valid = fv_reg;
    assign push_job   = job_reg;

    // A fill skips the rest of a leading partial granule.
    assign lead      = base_addr[2:0];
    assign lead_nz   = (lead != 3'd0);
    assign rest      = 4'd8 - {1'b0, lead};
    assign fill_go   = !lead_nz || ({{(spcf_pkg::CNT_W-4){1'b0}}, rest} < byte_count);
    assign fill_cnt  = lead_nz ? (byte_count - {{(spcf_pkg::CNT_W-4){1'b0}}, rest})
                               : byte_count;
    assign fill_gran = base_addr[spcf_pkg::ADDR_W-1:3]
                       + {{(spcf_pkg::GRAN_W-1){1'b0}}, lead_nz};
    assign fill_sum  = {1'b0, fill_cnt} + spcf_pkg::REM_W'(7);

    // A check counts the low address bits as part of the range.
    assign chk_rem = {1'b0, byte_count} + {{(spcf_pkg::REM_W-3){1'b0}}, lead};
    assign chk_sum = chk_rem + spcf_pkg::REM_W'(7);

    // Classify the incoming transaction into a walk description.
    always_comb
    begin
        job_next       = job_reg;
        gran           = base_addr[spcf_pkg::ADDR_W-1:3];
        job_next.op    = kind;
        job_next.value = fill_value;
        case (kind)
            spcf_pkg::KIND_FILL:
            begin
                gran           = fill_gran;
                job_next.rem   = {1'b0, fill_cnt};
                job_next.ngran = fill_go ? fill_sum[spcf_pkg::REM_W-1:3]
                                         : '0;
            end
            spcf_pkg::KIND_ANY, spcf_pkg::KIND_ALL:
            begin
                job_next.rem   = chk_rem;
                job_next.ngran = chk_sum[spcf_pkg::REM_W-1:3];
            end
            default:
            begin
                job_next.rem   = chk_rem;
                job_next.ngran = '0;
            end
        endcase
        job_next.gran = gran;
        job_next.off  = gran - region_base;
    end

    // Holding stage valid flag.
    always_comb
    begin
        fv_next = fv_reg;
        if (accept)
        begin
            fv_next = 1'b1;
        end
        else if (push_ready)
        begin
            fv_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= 1'b0;
        end
        else
        begin
            fv_reg <= fv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            job_reg <= job_next;
        end
    end

endmodule

// ===== hdl/spcf_queue.sv =====
module spcf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  spcf_pkg::job_t push_job,
    output logic           pop_valid,
    input  logic           pop_ready,
    output spcf_pkg::job_t pop_job
);

    localparam int PTR_W = (spcf_pkg::QUEUE_DEPTH > 1) ? $clog2(spcf_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(spcf_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(spcf_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(spcf_pkg::QUEUE_DEPTH);

    spcf_pkg::job_t   slot_reg [spcf_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_reg;
    logic [PTR_W-1:0] wr_next;
    logic [PTR_W-1:0] rd_reg;
    logic [PTR_W-1:0] rd_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (cnt_reg != CNT_FULL);
    assign pop_valid  = (cnt_reg != '0);
    assign pop_job    = slot_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and fill level bookkeeping.
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (do_push)
        begin
            wr_next = (wr_reg == PTR_LAST) ? '0 : wr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_next = (rd_reg == PTR_LAST) ? '0 : rd_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg] <= push_job;
        end
    end

endmodule

// ===== hdl/spcf_back.sv =====
module spcf_back (
    input  logic                         clk,
    input  logic                         rst_n,
    output logic                         clear_done,
    input  logic                         pop_valid,
    output logic                         pop_ready,
    input  spcf_pkg::job_t               pop_job,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         verdict,
    output logic [spcf_pkg::ADDR_W-1:0]  first_invalid_addr,
    output logic                         skipped_out_of_range
);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_WALK  = 2'd2;

    localparam int AW = spcf_pkg::SHADOW_AW;
    localparam logic [AW-1:0] CLR_LAST = AW'(spcf_pkg::SHADOW_ENTRIES - 1);

    logic [1:0]                     state_reg,  state_next;
    logic [AW-1:0]                  clr_reg,    clr_next;
    logic [1:0]                     op_reg,     op_next;
    logic [spcf_pkg::GRAN_W-1:0]    off_reg,    off_next;
    logic [spcf_pkg::GRAN_W-1:0]    gran_reg,   gran_next;
    logic [spcf_pkg::NGRAN_W-1:0]   left_reg,   left_next;
    logic [spcf_pkg::REM_W-1:0]     rem_reg,    rem_next;
    logic [spcf_pkg::VAL_W-1:0]     val_reg,    val_next;
    logic                           skip_reg,   skip_next;
    logic                           pv_reg,     pv_next;
    logic                           pin_reg,    pin_next;
    logic [spcf_pkg::GRAN_W-1:0]    pgran_reg,  pgran_next;
    logic [spcf_pkg::REM_W-1:0]     prem_reg,   prem_next;
    logic                           ov_reg,     ov_next;
    logic                           verd_reg,   verd_next;
    logic [spcf_pkg::ADDR_W-1:0]    first_reg,  first_next;
    logic                           oskip_reg,  oskip_next;

    logic                           clearing;
    logic                           in_range;
    logic                           is_check;
    logic                           issue;
    logic                           hit_any;
    logic                           hit_all;
    logic                           hit;
    logic                           skip_eval;
    logic [spcf_pkg::REM_W-1:0]     s_ext;
    logic [spcf_pkg::VAL_W-1:0]     fill_byte;
    logic                           ram_we;
    logic [AW-1:0]                  ram_waddr;
    logic [spcf_pkg::VAL_W-1:0]     ram_wdata;
    logic [spcf_pkg::VAL_W-1:0]     ram_rdata;

    assign clearing             = (state_reg == ST_CLEAR);
    assign clear_done           = !clearing;
    assign pop_ready            = (state_reg == ST_IDLE) && !ov_reg;
    assign out_valid            = ov_reg;
    assign verdict              = verd_reg;
    assign first_invalid_addr   = first_reg;
    assign skipped_out_of_range = oskip_reg;

    // Issue side: one shadow entry per cycle.
    assign in_range = (off_reg < spcf_pkg::ENTRIES_LIM);
    assign is_check = (op_reg == spcf_pkg::KIND_ANY) || (op_reg == spcf_pkg::KIND_ALL);
    assign issue    = (state_reg == ST_WALK) && (left_reg != '0) && !hit;

    // A final partial granule of a nonzero fill gets its byte count.
    assign fill_byte = ((rem_reg >= spcf_pkg::REM_W'(8)) || (val_reg == '0))
                       ? val_reg : {5'b0, rem_reg[2:0]};

    assign ram_we    = clearing || (issue && (op_reg == spcf_pkg::KIND_FILL) && in_range);
    assign ram_waddr = clearing ? clr_reg : off_reg[AW-1:0];
    assign ram_wdata = clearing ? '0 : fill_byte;

    spcf_ram #(
        .WIDTH(spcf_pkg::VAL_W),
        .DEPTH(spcf_pkg::SHADOW_ENTRIES)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(off_reg[AW-1:0]),
        .rdata(ram_rdata)
    );

    // Evaluate side: the entry read in the previous cycle.
    assign s_ext     = {{(spcf_pkg::REM_W-spcf_pkg::VAL_W){1'b0}}, ram_rdata};
    assign hit_any   = (ram_rdata != '0) && ((prem_reg > spcf_pkg::REM_W'(8))
                       || (s_ext < prem_reg) || (ram_rdata > spcf_pkg::VAL_W'(7)));
    assign hit_all   = (ram_rdata <= spcf_pkg::VAL_W'(8)) && (s_ext < prem_reg);
    assign hit       = pv_reg && pin_reg
                       && ((op_reg == spcf_pkg::KIND_ANY) ? hit_any : hit_all);
    assign skip_eval = pv_reg && !pin_reg;

    // Sequencer for clearing, walking and posting the result.
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        op_next    = op_reg;
        off_next   = off_reg;
        gran_next  = gran_reg;
        left_next  = left_reg;
        rem_next   = rem_reg;
        val_next   = val_reg;
        skip_next  = skip_reg;
        pv_next    = pv_reg;
        pin_next   = pin_reg;
        pgran_next = pgran_reg;
        prem_next  = prem_reg;
        ov_next    = ov_reg;
        verd_next  = verd_reg;
        first_next = first_reg;
        oskip_next = oskip_reg;

        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == CLR_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (pop_valid && pop_ready)
                begin
                    op_next    = pop_job.op;
                    off_next   = pop_job.off;
                    gran_next  = pop_job.gran;
                    left_next  = pop_job.ngran;
                    rem_next   = pop_job.rem;
                    val_next   = pop_job.value;
                    skip_next  = 1'b0;
                    pv_next    = 1'b0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                pv_next    = issue && is_check;
                pin_next   = in_range;
                pgran_next = gran_reg;
                prem_next  = rem_reg;
                if (issue)
                begin
                    off_next  = off_reg + spcf_pkg::GRAN_W'(1);
                    gran_next = gran_reg + spcf_pkg::GRAN_W'(1);
                    left_next = left_reg - spcf_pkg::NGRAN_W'(1);
                    rem_next  = rem_reg - spcf_pkg::REM_W'(8);
                end
                skip_next = skip_reg || skip_eval
                            || (issue && (op_reg == spcf_pkg::KIND_FILL) && !in_range);
                if (hit)
                begin
                    ov_next    = 1'b1;
                    verd_next  = (op_reg == spcf_pkg::KIND_ANY);
                    first_next = {pgran_reg, 3'b000};
                    oskip_next = skip_reg;
                    pv_next    = 1'b0;
                    state_next = ST_IDLE;
                end
                else if (left_reg == '0)
                begin
                    ov_next    = 1'b1;
                    verd_next  = (op_reg == spcf_pkg::KIND_ALL);
                    first_next = '0;
                    oskip_next = skip_reg || skip_eval;
                    pv_next    = 1'b0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            left_reg  <= '0;
            pv_reg    <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            left_reg  <= left_next;
            pv_reg    <= pv_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload of the walk and of the result.
    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        off_reg   <= off_next;
        gran_reg  <= gran_next;
        rem_reg   <= rem_next;
        val_reg   <= val_next;
        skip_reg  <= skip_next;
        pin_reg   <= pin_next;
        pgran_reg <= pgran_next;
        prem_reg  <= prem_next;
        verd_reg  <= verd_next;
        first_reg <= first_next;
        oskip_reg <= oskip_next;
    end

endmodule

// ===== hdl/spcf_checker.sv =====
module spcf_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic                          verdict,
    input  logic [spcf_pkg::ADDR_W-1:0]   first_invalid_addr,
    input  logic                          skipped_out_of_range
);

    // The block neither takes nor offers a transaction while held in reset.
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid && !in_ready)
        else $error("transaction offered during reset");

    // A reported granule address is always granule aligned.
    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> first_invalid_addr[2:0] == 3'b000)
        else $error("first_invalid_addr not granule aligned");

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(verdict)
            && $stable(first_invalid_addr) && $stable(skipped_out_of_range))
        else $error("stalled result changed");

    // The first cycle after reset is spent clearing the store.
    a_clear_first: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("request accepted before the shadow store was cleared");

endmodule

bind shadow_poison_check_fill spcf_checker u_spcf_checker (.*);
